// ===== rtl/tdbs_pkg.sv =====
package tdbs_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int HOLD_W    = 16;
  localparam logic [ADDR_W-3:0] REG_PHASE_HOLD = 1'b0;
  localparam logic [HOLD_W-1:0] PHASE_HOLD_RESET = 16'd100;

  localparam int QUEUE_DEPTH = 2;

  localparam int PHASE_W = 5;
  localparam logic [PHASE_W-1:0] BIT_PHASES   = 5'd24;
  localparam logic [PHASE_W-1:0] ACK_CLK_LOW  = 5'd24;
  localparam logic [PHASE_W-1:0] ACK_CLK_HIGH = 5'd25;
  localparam logic [PHASE_W-1:0] ACK_SAMPLE   = 5'd26;
  localparam logic [PHASE_W-1:0] ACK_END      = 5'd27;
  localparam logic [PHASE_W-1:0] STOP_CLK     = 5'd1;
  localparam logic [PHASE_W-1:0] STOP_END     = 5'd2;
  localparam logic [1:0] SUB_LAST = 2'd2;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_WRITE,
    KIND_STOP
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic       ack_line_level;
  } in_item_t;

  typedef struct packed {
    logic clock_released;
    logic data_released;
    logic ack_seen_high;
    logic last_phase;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] byte_value;
    logic       ack_line_level;
  } cmd_t;

endpackage

// ===== rtl/tdbs_front.sv =====
module tdbs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tdbs_pkg::in_item_t in_data,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output tdbs_pkg::cmd_t  cmd
);
  import tdbs_pkg::*;

  logic      stage_valid;
  cmd_t      stage_cmd;
  cmd_t      cmd_next;
  logic      keep;
  logic      accept;

  assign in_ready  = !stage_valid || cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = stage_valid;
  assign cmd       = stage_cmd;

  always_comb begin
    cmd_next.byte_value     = in_data.byte_value;
    cmd_next.ack_line_level = in_data.ack_line_level;
    cmd_next.kind           = KIND_START;
    keep                    = 1'b1;
    unique case (in_data.opcode)
      OP_START: cmd_next.kind = KIND_START;
      OP_WRITE: cmd_next.kind = KIND_WRITE;
      OP_STOP:  cmd_next.kind = KIND_STOP;
      default:  keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= keep;
    end else if (cmd_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_cmd <= cmd_next;
    end
  end

endmodule

// ===== rtl/tdbs_queue.sv =====
module tdbs_queue #(
  parameter int DEPTH = tdbs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tdbs_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tdbs_pkg::cmd_t pop_cmd
);
  import tdbs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/tdbs_back.sv =====
module tdbs_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tdbs_pkg::HOLD_W-1:0]    phase_hold_cycles,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  tdbs_pkg::cmd_t                 cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tdbs_pkg::out_item_t            out_data
);
  import tdbs_pkg::*;

  logic                busy;
  cmd_kind_t           kind;
  logic [7:0]          shift;
  logic                ack;
  logic [PHASE_W-1:0]  phase;
  logic [1:0]          sub;
  logic [HOLD_W-1:0]   hold_cnt;
  logic                clk_lvl;
  logic                dat_lvl;
  out_item_t           out_reg;
  logic                out_vld;

  logic                emit;
  logic                clk_lvl_next;
  logic                dat_lvl_next;
  logic                ack_o;
  logic                last;
  logic                in_bits;

  assign cmd_ready = !busy;
  assign out_valid = out_vld;
  assign out_data  = out_reg;
  assign in_bits   = phase < BIT_PHASES;
  assign emit      = busy && (hold_cnt <= HOLD_W'(1)) && (!out_vld || out_ready);

  always_comb begin
    clk_lvl_next = clk_lvl;
    dat_lvl_next = dat_lvl;
    ack_o        = 1'b0;
    last         = 1'b0;
    unique case (kind)
      KIND_START: begin
        dat_lvl_next = 1'b0;
        last         = 1'b1;
      end
      KIND_STOP: begin
        if (phase == STOP_END) begin
          dat_lvl_next = 1'b1;
          last         = 1'b1;
        end else if (phase == STOP_CLK) begin
          clk_lvl_next = 1'b1;
        end else begin
          dat_lvl_next = 1'b0;
        end
      end
      KIND_WRITE: begin
        if (in_bits) begin
          case (sub)
            2'd0:    clk_lvl_next = 1'b0;
            2'd1:    dat_lvl_next = shift[0];
            default: clk_lvl_next = 1'b1;
          endcase
        end else if (phase == ACK_CLK_LOW) begin
          clk_lvl_next = 1'b0;
          dat_lvl_next = 1'b1;
        end else if (phase == ACK_CLK_HIGH) begin
          clk_lvl_next = 1'b1;
        end else if (phase == ACK_SAMPLE) begin
          if (!ack) begin
            dat_lvl_next = 1'b0;
          end
        end else begin
          clk_lvl_next = 1'b0;
          ack_o        = ack;
          last         = 1'b1;
        end
      end
      default: last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      hold_cnt <= '0;
      clk_lvl  <= 1'b1;
      dat_lvl  <= 1'b1;
      out_vld  <= 1'b0;
      phase    <= '0;
      sub      <= '0;
    end else begin
      if (emit) begin
        hold_cnt <= phase_hold_cycles;
      end else if (hold_cnt != '0) begin
        hold_cnt <= hold_cnt - 1'b1;
      end

      if (emit) begin
        out_vld <= 1'b1;
      end else if (out_ready) begin
        out_vld <= 1'b0;
      end

      if (!busy && cmd_valid) begin
        busy  <= 1'b1;
        phase <= '0;
        sub   <= '0;
      end else if (emit) begin
        clk_lvl <= clk_lvl_next;
        dat_lvl <= dat_lvl_next;
        phase   <= phase + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
        if (in_bits) begin
          sub <= (sub == SUB_LAST) ? 2'd0 : sub + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && cmd_valid) begin
      kind  <= cmd.kind;
      shift <= cmd.byte_value;
      ack   <= cmd.ack_line_level;
    end else if (emit && in_bits && sub == SUB_LAST) begin
      shift <= {1'b0, shift[7:1]};
    end
    if (emit) begin
      out_reg.clock_released <= clk_lvl_next;
      out_reg.data_released  <= dat_lvl_next;
      out_reg.ack_seen_high  <= ack_o;
      out_reg.last_phase     <= last;
    end
  end

endmodule

// ===== rtl/two_wire_display_byte_sender_unit.sv =====
// path: a command passes the front-end stage register, the queue and the back-end command
// registers before its first pin phase is registered in the output register
// each phase is held by the back-end hold timer, which is loaded from phase_hold_cycles
// pin phases per command: start 1, stop 3, byte write 28; the back end takes the next
// command only after the last phase of the current one has been emitted
// reset: both lines released, queue emptied, phase_hold_cycles back to 100
module two_wire_display_byte_sender_unit #(
  parameter int QUEUE_DEPTH = tdbs_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tdbs_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tdbs_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdbs_pkg::ADDR_W-1:0]   paddr,
  input  logic [tdbs_pkg::DATA_W-1:0]   pwdata,
  output logic [tdbs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tdbs_pkg::*;

  logic [HOLD_W-1:0] phase_hold_cycles;
  logic              reg_sel;
  logic              f_valid;
  logic              f_ready;
  cmd_t              f_cmd;
  logic              q_valid;
  logic              q_ready;
  cmd_t              q_cmd;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1:2] == REG_PHASE_HOLD;
  assign prdata  = reg_sel ? {{(DATA_W-HOLD_W){1'b0}}, phase_hold_cycles} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_hold_cycles <= PHASE_HOLD_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      phase_hold_cycles <= pwdata[HOLD_W-1:0];
    end
  end

  tdbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  tdbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  tdbs_back u_back (
    .clk               (clk),
    .rst               (rst),
    .phase_hold_cycles (phase_hold_cycles),
    .cmd_valid         (q_valid),
    .cmd_ready         (q_ready),
    .cmd               (q_cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data)
  );

endmodule

// ===== rtl/tdbs_checker.sv =====
module tdbs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input tdbs_pkg::out_item_t           out_data,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [tdbs_pkg::ADDR_W-1:0]   paddr,
  input logic [tdbs_pkg::DATA_W-1:0]   pwdata,
  input logic [tdbs_pkg::DATA_W-1:0]   prdata,
  input logic                          pready
);
  import tdbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.ack_seen_high |-> out_data.last_phase && !out_data.clock_released)
    else $error("acknowledge reported outside final clock-low phase");

  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_PHASE_HOLD
    |=> paddr[ADDR_W-1:2] != REG_PHASE_HOLD
        || prdata == {{(DATA_W-HOLD_W){1'b0}}, $past(pwdata[HOLD_W-1:0])})
    else $error("phase hold register readback mismatch");

endmodule

bind two_wire_display_byte_sender_unit tdbs_checker u_tdbs_checker (.*);

// ===== tb/sv/tb.sv =====
module tb;
  import tdbs_pkg::*;

  localparam logic [ADDR_W-3:0] REG_UNMAPPED = 1'b1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  two_wire_display_byte_sender_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  int                errors = 0;
  int                send_idle_pct = 14;
  int                recv_idle_pct = 76;
  int                recv_hold_off = 0;
  logic [HOLD_W-1:0] cur_hold = PHASE_HOLD_RESET;

  // predicted pin levels and pending pin phases
  logic      clk_line = 1'b1;
  logic      dat_line = 1'b1;
  out_item_t pin_phase_q[$];

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2500000;
    $display("Some tests failed");
    $finish;
  end

  function automatic in_item_t make_cmd(logic [1:0] op, logic [7:0] value, logic ack);
    return '{opcode: op, byte_value: value, ack_line_level: ack};
  endfunction

  function automatic void push_phase(logic ack, logic last);
    pin_phase_q.push_back('{clock_released: clk_line, data_released: dat_line,
                            ack_seen_high: ack, last_phase: last});
  endfunction

  function automatic void predict_pin_phases(in_item_t c);
    logic [7:0] bits;
    bits = c.byte_value;
    case (c.opcode)
      OP_START: begin
        dat_line = 1'b0;
        push_phase(1'b0, 1'b1);
      end
      OP_STOP: begin
        dat_line = 1'b0;
        push_phase(1'b0, 1'b0);
        clk_line = 1'b1;
        push_phase(1'b0, 1'b0);
        dat_line = 1'b1;
        push_phase(1'b0, 1'b1);
      end
      OP_WRITE: begin
        for (int i = 0; i < 8; i++) begin
          clk_line = 1'b0;
          push_phase(1'b0, 1'b0);
          dat_line = bits[0];
          push_phase(1'b0, 1'b0);
          clk_line = 1'b1;
          push_phase(1'b0, 1'b0);
          bits = bits >> 1;
        end
        // acknowledge slot
        clk_line = 1'b0;
        dat_line = 1'b1;
        push_phase(1'b0, 1'b0);
        clk_line = 1'b1;
        push_phase(1'b0, 1'b0);
        if (!c.ack_line_level) dat_line = 1'b0;
        push_phase(1'b0, 1'b0);
        clk_line = 1'b0;
        push_phase(c.ack_line_level, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void field_check(string name, logic want, logic got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0b got %0b", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : pin_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pin_phase_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction expected none got %p", $time, out_data);
      end else begin
        want = pin_phase_q.pop_front();
        field_check("clock_released", want.clock_released, out_data.clock_released);
        field_check("data_released", want.data_released, out_data.data_released);
        field_check("ack_seen_high", want.ack_seen_high, out_data.ack_seen_high);
        field_check("last_phase", want.last_phase, out_data.last_phase);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (recv_hold_off > 0) begin
        out_ready <= 1'b0;
        recv_hold_off--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_cmd(input in_item_t c);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    predict_pin_phases(c);
  endtask

  // drop valid, wait for all pending phases, optionally let the block settle
  task automatic wait_idle(input bit settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_phase_q.size() != 0) @(posedge clk);
    if (settle) repeat (int'(cur_hold) + 20) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-3:0] idx,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_hold_readback();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, REG_PHASE_HOLD, '0, rd);
    if (rd[HOLD_W-1:0] !== cur_hold) begin
      errors++;
      $display("%0t: phase_hold_cycles expected %0d got %0d", $time, cur_hold, rd[HOLD_W-1:0]);
    end
  endtask

  task automatic set_phase_hold(input logic [HOLD_W-1:0] value);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, REG_PHASE_HOLD, DATA_W'(value), rd);
    cur_hold = value;
    check_hold_readback();
  endtask

  task automatic test_directed_commands();
    check_hold_readback();
    send_cmd(make_cmd(OP_START, 8'h00, 1'b0));
    send_cmd(make_cmd(OP_WRITE, 8'h00, 1'b0));
    send_cmd(make_cmd(OP_WRITE, 8'hFF, 1'b1));
    send_cmd(make_cmd(OP_WRITE, 8'hA5, 1'b1));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0));
    send_cmd(make_cmd(OP_UNUSED, 8'hFF, 1'b1));
    send_cmd(make_cmd(OP_STOP, 8'hFF, 1'b1));
    send_cmd(make_cmd(OP_WRITE, 8'h5A, 1'b0));
    send_cmd(make_cmd(OP_START, 8'hFF, 1'b1));
    send_cmd(make_cmd(OP_START, 8'h00, 1'b0));
    send_cmd(make_cmd(OP_WRITE, 8'h01, 1'b0));
    send_cmd(make_cmd(OP_WRITE, 8'h80, 1'b1));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0));
    wait_idle(1'b1);
  endtask

  task automatic test_hold_extremes();
    logic [DATA_W-1:0] rd;
    set_phase_hold(16'hFFFF);
    send_cmd(make_cmd(OP_START, 8'h00, 1'b0));
    wait_idle(1'b1);
    // zero hold still moves the pins
    set_phase_hold(16'd0);
    send_cmd(make_cmd(OP_WRITE, 8'h3C, 1'b1));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0));
    wait_idle(1'b1);
    // unmapped register leaves the hold alone
    apb_access(1'b1, REG_UNMAPPED, 32'h0000_1234, rd);
    check_hold_readback();
    set_phase_hold(16'd1);
    send_cmd(make_cmd(OP_START, 8'h00, 1'b0));
    send_cmd(make_cmd(OP_WRITE, 8'hC3, 1'b0));
    wait_idle(1'b1);
  endtask

  task automatic test_input_backpressure();
    send_idle_pct = 0;
    set_phase_hold(16'd1);
    recv_hold_off = 300;
    send_cmd(make_cmd(OP_START, 8'h00, 1'b0));
    for (int k = 0; k < 4; k++)
      send_cmd(make_cmd(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1))));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0));
    wait_idle(1'b0);
    send_cmd(make_cmd(OP_WRITE, 8'h96, 1'b1));
    send_cmd(make_cmd(OP_STOP, 8'h00, 1'b0));
    wait_idle(1'b1);
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
    int         sent;
    int         n_writes;
    logic [1:0] op;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    set_phase_hold(HOLD_W'($urandom_range(1, 4)));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        send_cmd(make_cmd(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1))));
        n_writes = $urandom_range(1, 4);
        for (int k = 0; k < n_writes; k++)
          send_cmd(make_cmd(OP_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1))));
        send_cmd(make_cmd(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1))));
        sent += n_writes + 2;
      end else begin
        op = 2'($urandom_range(3));
        send_cmd(make_cmd(op, 8'($urandom_range(255)), 1'($urandom_range(1))));
        if (op != OP_UNUSED) sent++;
      end
      if ($urandom_range(19) == 0) wait_idle(1'b0);
    end
    wait_idle(1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_hold_extremes();
    test_input_backpressure();
    test_random_traffic(14, 76, 46);
    test_random_traffic(76, 14, 46);
    test_random_traffic(0, 0, 46);
    wait_idle(1'b1);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tdbs_pkg.sv
rtl/tdbs_front.sv
rtl/tdbs_queue.sv
rtl/tdbs_back.sv
rtl/two_wire_display_byte_sender_unit.sv
rtl/tdbs_checker.sv
tb/sv/tb.sv
